@@ rtl/ppws_pkg.sv @@
// Package for the pulse peak weighted-sum block: sizes, operation and
// register codes, and the control struct of the multiply-accumulate unit.
// No dependencies.
`default_nettype none

package ppws_pkg;

  // Table depth and effective weight width.
  localparam int MAX_TAPS    = 64;
  localparam int WEIGHT_BITS = 16;
  localparam int W_EFF       = (WEIGHT_BITS < 16) ? WEIGHT_BITS : 16;
  localparam int TAP_AW      = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int CNT_W       = $clog2(MAX_TAPS + 1);

  // Field widths of the channels.
  localparam int OP_W      = 2;
  localparam int IDX_W     = 6;
  localparam int WFIELD_W  = 16;
  localparam int SMP_W     = 10;
  localparam int OUT_W     = 32;

  // Register widths and codes.
  localparam int TAP_CNT_W  = 7;
  localparam int THR_W      = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_AMP_THRESHOLD = 1'b1;
  localparam logic [THR_W-1:0]     THR_RESET         = 16'd900;

  // Operation codes of an input item.
  localparam logic [OP_W-1:0] OP_LOAD_AMP  = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD_TIME = 2'd1;
  localparam logic [OP_W-1:0] OP_SAMPLE    = 2'd2;

  // Arithmetic sizes: Q12 sums, Q8 time dividend.
  localparam int FRAC_BITS = 12;
  localparam int TIME_FRAC = 8;
  localparam int PROD_W    = W_EFF + SMP_W + 1;
  localparam int SUM_W     = 34;
  localparam int DIVD_W    = SUM_W + TIME_FRAC;

  localparam logic [SMP_W-1:0]        SAMPLE_FULL = 10'd1023;
  localparam logic signed [SUM_W-1:0] AMP_FORCED  = SUM_W'(1023 * 4096);

  // Commands to the multiply-accumulate unit.
  typedef struct packed {
    logic clear;
    logic acc_amp;
    logic acc_time;
  } mac_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/ppws_in_if.sv @@
// Input channel of the pulse peak weighted-sum block: valid/ready plus
// the load and sample fields. Depends on ppws_pkg.
`default_nettype none

interface ppws_in_if;
  import ppws_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [OP_W-1:0]            operation;
  logic [IDX_W-1:0]           weight_index;
  logic signed [WFIELD_W-1:0] weight_value;
  logic [SMP_W-1:0]           sample;
  logic                       last_sample;

  modport source (
    output valid, operation, weight_index, weight_value, sample, last_sample,
    input  ready
  );

  modport sink (
    input  valid, operation, weight_index, weight_value, sample, last_sample,
    output ready
  );
endinterface

`default_nettype wire

@@ rtl/ppws_out_if.sv @@
// Result channel of the pulse peak weighted-sum block: valid/ready plus
// amplitude, peak time and the divide-by-zero flag. Depends on ppws_pkg.
`default_nettype none

interface ppws_out_if;
  import ppws_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] amplitude;
  logic signed [OUT_W-1:0] peak_time;
  logic                    divide_by_zero;

  modport source (
    output valid, amplitude, peak_time, divide_by_zero,
    input  ready
  );

  modport sink (
    input  valid, amplitude, peak_time, divide_by_zero,
    output ready
  );
endinterface

`default_nettype wire

@@ rtl/ppws_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module ppws_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/ppws_mac.sv @@
// Shared multiply-accumulate unit: one multiplier serves the amplitude and
// the time sum in turn, and the peak sample is tracked. Depends on ppws_pkg.
`default_nettype none

module ppws_mac (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire ppws_pkg::mac_ctrl_t        ctrl,
  input  wire logic [ppws_pkg::W_EFF-1:0] amp_weight,
  input  wire logic [ppws_pkg::W_EFF-1:0] time_weight,
  input  wire logic [ppws_pkg::SMP_W-1:0] sample,
  output      logic signed [ppws_pkg::SUM_W-1:0] amp_sum,
  output      logic signed [ppws_pkg::SUM_W-1:0] time_sum,
  output      logic [ppws_pkg::SMP_W-1:0] max_seen
);
  import ppws_pkg::*;

  logic signed [W_EFF-1:0]  weight_sel;
  logic signed [PROD_W-1:0] product;
  logic signed [SUM_W-1:0]  amp_sum_r, amp_sum_nxt;
  logic signed [SUM_W-1:0] time_sum_r, time_sum_nxt;
  logic [SMP_W-1:0]         max_seen_r, max_seen_nxt;

  // One multiplier; the operand select picks the table being accumulated.
  assign weight_sel = ctrl.acc_time ? $signed(time_weight) : $signed(amp_weight);
  assign product    = PROD_W'(weight_sel) * $signed({1'b0, sample});

  always_comb begin
    amp_sum_nxt  = amp_sum_r;
    time_sum_nxt = time_sum_r;
    max_seen_nxt = max_seen_r;
    if (ctrl.clear) begin
      amp_sum_nxt  = '0;
      time_sum_nxt = '0;
      max_seen_nxt = '0;
    end else if (ctrl.acc_amp) begin
      amp_sum_nxt = amp_sum_r + SUM_W'(product);
      if (sample > max_seen_r) begin
        max_seen_nxt = sample;
      end
    end else if (ctrl.acc_time) begin
      time_sum_nxt = time_sum_r + SUM_W'(product);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      amp_sum_r  <= '0;
      time_sum_r <= '0;
      max_seen_r <= '0;
    end else begin
      amp_sum_r  <= amp_sum_nxt;
      time_sum_r <= time_sum_nxt;
      max_seen_r <= max_seen_nxt;
    end
  end

  assign amp_sum  = amp_sum_r;
  assign time_sum = time_sum_r;
  assign max_seen = max_seen_r;

endmodule

`default_nettype wire

@@ rtl/ppws_div.sv @@
// Radix-2 restoring divider, one quotient bit per cycle, with truncation
// toward zero and saturation of the quotient to 32 bits. Depends on ppws_pkg.
`default_nettype none

module ppws_div (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               start,
  input  wire logic signed [ppws_pkg::DIVD_W-1:0] dividend,
  input  wire logic signed [ppws_pkg::SUM_W-1:0]  divisor,
  output      logic                               done,
  output      logic signed [ppws_pkg::OUT_W-1:0]  quotient
);
  import ppws_pkg::*;

  localparam int DCNT_W = $clog2(DIVD_W);
  localparam logic [DIVD_W-1:0] POS_LIM = DIVD_W'(64'h7FFF_FFFF);
  localparam logic [DIVD_W-1:0] NEG_LIM = DIVD_W'(64'h8000_0000);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DCNT_W-1:0] cnt_r, cnt_nxt;
  logic              neg_r, neg_nxt;
  logic [SUM_W-1:0]  dvs_r, dvs_nxt;
  logic [SUM_W-1:0]  rem_r, rem_nxt;
  logic [DIVD_W-1:0] quo_r, quo_nxt;
  logic [SUM_W:0]    shifted;
  logic [SUM_W+1:0]  diff;
  logic [DIVD_W-1:0] q_neg;

  // One trial subtraction per cycle.
  assign shifted = {rem_r, quo_r[DIVD_W-1]};
  assign diff    = {1'b0, shifted} - {2'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    neg_nxt  = neg_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    if (start) begin
      // Work on magnitudes; the sign is applied at the end.
      busy_nxt = 1'b1;
      cnt_nxt  = DCNT_W'(DIVD_W - 1);
      neg_nxt  = dividend[DIVD_W-1] ^ divisor[SUM_W-1];
      dvs_nxt  = divisor[SUM_W-1] ? SUM_W'(-divisor) : SUM_W'(divisor);
      rem_nxt  = '0;
      quo_nxt  = dividend[DIVD_W-1] ? DIVD_W'(-dividend) : DIVD_W'(dividend);
    end else if (busy_r) begin
      if (diff[SUM_W+1]) begin
        rem_nxt = shifted[SUM_W-1:0];
      end else begin
        rem_nxt = diff[SUM_W-1:0];
      end
      quo_nxt = {quo_r[DIVD_W-2:0], ~diff[SUM_W+1]};
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - DCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r <= neg_nxt;
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  // Sign and saturation of the finished quotient.
  assign q_neg = -quo_r;

  always_comb begin
    if (!neg_r) begin
      quotient = (quo_r > POS_LIM) ? $signed(OUT_W'(POS_LIM)) : $signed(quo_r[OUT_W-1:0]);
    end else begin
      quotient = (quo_r > NEG_LIM) ? $signed(OUT_W'(NEG_LIM)) : $signed(q_neg[OUT_W-1:0]);
    end
  end

  assign done = done_r;

endmodule

`default_nettype wire

@@ rtl/pulse_peak_weighted_sum_top.sv @@
// Top level of the pulse peak weighted-sum block: sequencer, weight tables,
// registers and result register. Depends on ppws_pkg, ppws_in_if,
// ppws_out_if, ppws_ram, ppws_mac and ppws_div.
//
//  Port     | Direction | Carries
//  ---------+-----------+------------------------------------------------
//  in_ch    | sink      | weight loads and trace samples, valid/ready
//  out_ch   | source    | amplitude, peak time, divide-by-zero flag
//  cfg_*    | input     | register writes: tap_count, amp_threshold
//
// A weight load, an ignored item or a sample past the taps is handled at its transfer.
// A sample inside the taps passes the transfer with the table read, then the shared
// multiplier once for each weighted sum. A trace end adds the threshold check, the
// divide state when the amplitude is nonzero, and a step that moves the result into
// the output register, which stalls while that is full.
// Reset clears the sums, counter and registers; the weight tables keep their contents.
`default_nettype none

module pulse_peak_weighted_sum_top (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  ppws_in_if.sink                                 in_ch,
  ppws_out_if.source                              out_ch,
  input  wire logic                               cfg_we,
  input  wire logic [ppws_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [ppws_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import ppws_pkg::*;

  localparam int ST_W = 3;
  localparam logic [ST_W-1:0] S_IDLE   = 3'd0;
  localparam logic [ST_W-1:0] S_MAC_A  = 3'd1;
  localparam logic [ST_W-1:0] S_MAC_T  = 3'd2;
  localparam logic [ST_W-1:0] S_FINISH = 3'd3;
  localparam logic [ST_W-1:0] S_DIV    = 3'd4;
  localparam logic [ST_W-1:0] S_RESULT = 3'd5;

  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(64'h7FFF_FFFF);
  localparam logic signed [SUM_W-1:0] SAT_LO = -SUM_W'(64'h8000_0000);

  logic [ST_W-1:0]      state_r, state_nxt;
  logic [TAP_CNT_W-1:0] tap_count_r;
  logic [THR_W-1:0]     amp_threshold_r;
  logic [CNT_W-1:0]     sample_count_r, sample_count_nxt;
  logic [SMP_W-1:0]     smp_r, smp_nxt;
  logic                 last_r, last_nxt;
  logic signed [SUM_W-1:0] amp_eff_r, amp_eff_nxt;

  logic signed [OUT_W-1:0] res_amp_r, res_amp_nxt;
  logic signed [OUT_W-1:0] res_time_r, res_time_nxt;
  logic                    res_dz_r, res_dz_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic signed [OUT_W-1:0] out_amp_r, out_amp_nxt;
  logic signed [OUT_W-1:0] out_time_r, out_time_nxt;
  logic                    out_dz_r, out_dz_nxt;

  logic                 in_xfer;
  logic                 load_ok;
  logic                 we_amp, we_time;
  logic [TAP_AW-1:0]    waddr, raddr;
  logic [W_EFF-1:0]     wdata;
  logic [W_EFF-1:0]     amp_w, time_w;
  logic [TAP_CNT_W-1:0] taps;
  logic                 tap_open;
  mac_ctrl_t            mac_ctrl;
  logic signed [SUM_W-1:0] amp_sum, time_sum;
  logic [SMP_W-1:0]     max_seen;
  logic signed [SUM_W-1:0] amp_calc;
  logic                 div_start, div_done;
  logic signed [OUT_W-1:0] div_q;
  logic                 out_free;
  logic                 div_pend_r;

  // Register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_count_r     <= '0;
      amp_threshold_r <= THR_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TAP_COUNT:     tap_count_r     <= cfg_wdata[TAP_CNT_W-1:0];
        REG_AMP_THRESHOLD: amp_threshold_r <= cfg_wdata[THR_W-1:0];
        default:           ;
      endcase
    end
  end

  // Taps in use and whether the current sample still falls inside them.
  assign taps     = (32'(tap_count_r) > MAX_TAPS) ? TAP_CNT_W'(MAX_TAPS) : tap_count_r;
  assign tap_open = 32'(sample_count_r) < 32'(taps);

  // Weight table writes happen on the load transfer itself.
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign load_ok     = 32'(in_ch.weight_index) < MAX_TAPS;
  assign we_amp      = in_xfer && (in_ch.operation == OP_LOAD_AMP) && load_ok;
  assign we_time     = in_xfer && (in_ch.operation == OP_LOAD_TIME) && load_ok;
  assign waddr       = TAP_AW'(in_ch.weight_index);
  assign wdata       = in_ch.weight_value[W_EFF-1:0];
  assign raddr       = TAP_AW'(sample_count_r);

  ppws_ram #(.WIDTH(W_EFF), .DEPTH(MAX_TAPS)) u_amp_ram (
    .clk   (clk),
    .we    (we_amp),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (amp_w)
  );

  ppws_ram #(.WIDTH(W_EFF), .DEPTH(MAX_TAPS)) u_time_ram (
    .clk   (clk),
    .we    (we_time),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (time_w)
  );

  ppws_mac u_mac (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctrl        (mac_ctrl),
    .amp_weight  (amp_w),
    .time_weight (time_w),
    .sample      (smp_r),
    .amp_sum     (amp_sum),
    .time_sum    (time_sum),
    .max_seen    (max_seen)
  );

  ppws_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({time_sum, {TIME_FRAC{1'b0}}}),
    .divisor  (amp_eff_r),
    .done     (div_done),
    .quotient (div_q)
  );

  // Amplitude after the full-scale check.
  always_comb begin
    if ((amp_sum > $signed({{(SUM_W-THR_W-FRAC_BITS){1'b0}}, amp_threshold_r,
                            {FRAC_BITS{1'b0}}})) && (max_seen == SAMPLE_FULL)) begin
      amp_calc = AMP_FORCED;
    end else begin
      amp_calc = amp_sum;
    end
  end

  assign out_free = !out_valid_r || out_ch.ready;

  // Sequencer.
  always_comb begin
    state_nxt        = state_r;
    sample_count_nxt = sample_count_r;
    smp_nxt          = smp_r;
    last_nxt         = last_r;
    amp_eff_nxt      = amp_eff_r;
    res_amp_nxt      = res_amp_r;
    res_time_nxt     = res_time_r;
    res_dz_nxt       = res_dz_r;
    mac_ctrl         = '0;
    div_start        = 1'b0;
    out_valid_nxt    = out_valid_r && !out_ch.ready;
    out_amp_nxt      = out_amp_r;
    out_time_nxt     = out_time_r;
    out_dz_nxt       = out_dz_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer && (in_ch.operation == OP_SAMPLE)) begin
          smp_nxt  = in_ch.sample;
          last_nxt = in_ch.last_sample;
          if (tap_open) begin
            state_nxt = S_MAC_A;
          end else if (in_ch.last_sample) begin
            state_nxt = S_FINISH;
          end
        end
      end
      S_MAC_A: begin
        mac_ctrl.acc_amp = 1'b1;
        state_nxt        = S_MAC_T;
      end
      S_MAC_T: begin
        mac_ctrl.acc_time = 1'b1;
        sample_count_nxt  = sample_count_r + CNT_W'(1);
        state_nxt         = last_r ? S_FINISH : S_IDLE;
      end
      S_FINISH: begin
        amp_eff_nxt = amp_calc;
        res_dz_nxt  = 1'b0;
        res_time_nxt = '0;
        if (taps == '0) begin
          res_amp_nxt = '0;
          state_nxt   = S_RESULT;
        end else begin
          if (amp_calc > SAT_HI) begin
            res_amp_nxt = OUT_W'(SAT_HI);
          end else if (amp_calc < SAT_LO) begin
            res_amp_nxt = OUT_W'(SAT_LO);
          end else begin
            res_amp_nxt = amp_calc[OUT_W-1:0];
          end
          if (amp_calc == '0) begin
            res_dz_nxt = 1'b1;
            state_nxt  = S_RESULT;
          end else begin
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV: begin
        // The divider starts on the first cycle here, when the divisor is
        // already registered.
        div_start = div_pend_r;
        if (div_done) begin
          res_time_nxt = div_q;
          state_nxt    = S_RESULT;
        end
      end
      S_RESULT: begin
        if (out_free) begin
          out_valid_nxt    = 1'b1;
          out_amp_nxt      = res_amp_r;
          out_time_nxt     = res_time_r;
          out_dz_nxt       = res_dz_r;
          mac_ctrl.clear   = 1'b1;
          sample_count_nxt = '0;
          state_nxt        = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Divider start: registered from the move into the divide state, so it is raised
  // in the first cycle there, when the registered amplitude is in place.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_pend_r <= 1'b0;
    end else begin
      div_pend_r <= (state_r == S_FINISH) && (state_nxt == S_DIV);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      sample_count_r <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      sample_count_r <= sample_count_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    smp_r      <= smp_nxt;
    last_r     <= last_nxt;
    amp_eff_r  <= amp_eff_nxt;
    res_amp_r  <= res_amp_nxt;
    res_time_r <= res_time_nxt;
    res_dz_r   <= res_dz_nxt;
    out_amp_r  <= out_amp_nxt;
    out_time_r <= out_time_nxt;
    out_dz_r   <= out_dz_nxt;
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.amplitude      = out_amp_r;
  assign out_ch.peak_time      = out_time_r;
  assign out_ch.divide_by_zero = out_dz_r;

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking bench for pulse_peak_weighted_sum_top: weight loads and traces, directed
// then random, with every result checked against an in-bench model of the weighted sums.
// Depends on ppws_pkg, ppws_in_if, ppws_out_if and the block's RTL.

module tb_top;
  import ppws_pkg::*;

  // Operation code that the block ignores.
  localparam logic [OP_W-1:0] OP_IGNORED = 2'd3;
  // Idle cycles after the last result: one sample, the threshold check and the divider.
  localparam int SETTLE_CYCLES = 64;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int RANDOM_ITEMS  = 850;
  localparam longint OUT_MAX   = (64'sd1 <<< (OUT_W - 1)) - 1;
  localparam longint OUT_MIN   = -(64'sd1 <<< (OUT_W - 1));

  typedef struct {
    logic [OP_W-1:0]            op;
    logic [IDX_W-1:0]           idx;
    logic signed [WFIELD_W-1:0] weight;
    logic [SMP_W-1:0]           smp;
    logic                       last;
  } pulse_item_t;

  typedef struct {
    logic signed [OUT_W-1:0] amplitude;
    logic signed [OUT_W-1:0] peak_time;
    logic                    div_zero;
  } peak_result_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  ppws_in_if  in_bus ();
  ppws_out_if out_bus ();

  pulse_peak_weighted_sum_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_bus),
    .out_ch    (out_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Model state: weight tables, running sums and register copies.
  logic signed [WFIELD_W-1:0] amp_taps  [MAX_TAPS];
  logic signed [WFIELD_W-1:0] time_taps [MAX_TAPS];
  longint      amp_acc;
  longint      time_acc;
  int unsigned peak_seen;
  int unsigned taps_taken;
  int unsigned tap_limit;
  int unsigned amp_limit;

  peak_result_t pending_peaks[$];
  int err_count     = 0;
  int items_sent    = 0;
  int peaks_checked = 0;
  bit gaps_on       = 1'b0;
  bit stalls_on     = 1'b0;
  int stall_left    = 0;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic logic signed [OUT_W-1:0] clamp_out(longint v);
    if (v > OUT_MAX) return OUT_MAX[OUT_W-1:0];
    if (v < OUT_MIN) return OUT_MIN[OUT_W-1:0];
    return v[OUT_W-1:0];
  endfunction

  // Advance the model by one accepted transfer; a trace end queues its result.
  function automatic void update_trace(pulse_item_t it);
    int unsigned  taps;
    longint       amp;
    longint       wa;
    longint       wt;
    longint       s;
    peak_result_t res;
    case (it.op)
      OP_LOAD_AMP:  amp_taps[it.idx] = it.weight;
      OP_LOAD_TIME: time_taps[it.idx] = it.weight;
      OP_SAMPLE: begin
        taps = (tap_limit > MAX_TAPS) ? MAX_TAPS : tap_limit;
        if (taps_taken < taps) begin
          s = longint'(it.smp);
          wa = amp_taps[taps_taken];
          wt = time_taps[taps_taken];
          amp_acc += wa * s;
          time_acc += wt * s;
          if (32'(it.smp) > peak_seen) peak_seen = 32'(it.smp);
          taps_taken++;
        end
        if (it.last) begin
          res.amplitude = '0;
          res.peak_time = '0;
          res.div_zero = 1'b0;
          if (taps != 0) begin
            amp = amp_acc;
            // A full-scale peak above the threshold pins the amplitude.
            if (amp > longint'(amp_limit) * (64'sd1 <<< FRAC_BITS) && peak_seen == SAMPLE_FULL)
              amp = longint'(AMP_FORCED);
            if (amp == 0) res.div_zero = 1'b1;
            else res.peak_time = clamp_out((time_acc * (64'sd1 <<< TIME_FRAC)) / amp);
            res.amplitude = clamp_out(amp);
          end
          pending_peaks.push_back(res);
          amp_acc = 0;
          time_acc = 0;
          peak_seen = 0;
          taps_taken = 0;
        end
      end
      default: ;
    endcase
  endfunction

  // Gap lengths: mostly short, a few long.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 93) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int pick_idle();
    if (!gaps_on || $urandom_range(0, 2) != 0) return 0;
    return gap_len();
  endfunction

  function automatic logic [SMP_W-1:0] pick_sample();
    int r;
    r = $urandom_range(0, 15);
    if (r < 2) return SAMPLE_FULL;
    if (r == 2) return '0;
    return SMP_W'($urandom_range(0, 1023));
  endfunction

  function automatic pulse_item_t make_sample(logic [SMP_W-1:0] smp, logic last);
    pulse_item_t it;
    it.op = OP_SAMPLE;
    it.idx = IDX_W'($urandom_range(0, 63));
    it.weight = WFIELD_W'($urandom_range(0, 65535));
    it.smp = smp;
    it.last = last;
    return it;
  endfunction

  function automatic pulse_item_t make_other(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx,
                                             logic signed [WFIELD_W-1:0] weight);
    pulse_item_t it;
    it.op = op;
    it.idx = idx;
    it.weight = weight;
    it.smp = SMP_W'($urandom_range(0, 1023));
    it.last = 1'($urandom_range(0, 1));
    return it;
  endfunction

  // Result side: random stalls on ready, driven at the falling edge.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_bus.ready = 1'b0;
      stall_left--;
    end else begin
      out_bus.ready = 1'b1;
      if (stalls_on && $urandom_range(0, 5) == 0) stall_left = gap_len();
    end
  end

  // Compare every result transfer with the oldest expected result.
  always @(posedge clk) begin : check_peaks
    peak_result_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pending_peaks.size() == 0) begin
        $error("unexpected result: amplitude %0d peak_time %0d", out_bus.amplitude,
               out_bus.peak_time);
        err_count++;
      end else begin
        want = pending_peaks.pop_front();
        peaks_checked++;
        if (out_bus.amplitude !== want.amplitude) begin
          $error("amplitude: expected %0d, got %0d", want.amplitude, out_bus.amplitude);
          err_count++;
        end
        if (out_bus.peak_time !== want.peak_time) begin
          $error("peak_time: expected %0d, got %0d", want.peak_time, out_bus.peak_time);
          err_count++;
        end
        if (out_bus.divide_by_zero !== want.div_zero) begin
          $error("divide_by_zero: expected %0b, got %0b", want.div_zero,
                 out_bus.divide_by_zero);
          err_count++;
        end
      end
    end
  end

  // Offer one item at the falling edge and hold it until the transfer.
  task automatic send_item(pulse_item_t it);
    int idle;
    idle = pick_idle();
    if (idle > 0) begin
      in_bus.valid = 1'b0;
      repeat (idle) @(negedge clk);
    end
    in_bus.operation = it.op;
    in_bus.weight_index = it.idx;
    in_bus.weight_value = it.weight;
    in_bus.sample = it.smp;
    in_bus.last_sample = it.last;
    in_bus.valid = 1'b1;
    do @(posedge clk); while (!in_bus.ready);
    update_trace(it);
    if (it.op != OP_IGNORED) items_sent++;
    @(negedge clk);
  endtask

  task automatic load_weight(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx,
                             logic signed [WFIELD_W-1:0] weight);
    send_item(make_other(op, idx, weight));
  endtask

  task automatic send_sample(logic [SMP_W-1:0] smp, logic last);
    send_item(make_sample(smp, last));
  endtask

  // Hold the input until every expected result is in, then let the block settle.
  task automatic wait_drained();
    int waited;
    in_bus.valid = 1'b0;
    waited = 0;
    while (pending_peaks.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    if (pending_peaks.size() != 0) begin
      $error("%0d expected results never arrived", pending_peaks.size());
      err_count++;
      pending_peaks.delete();
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == REG_TAP_COUNT) tap_limit = 32'(value[TAP_CNT_W-1:0]);
    else amp_limit = 32'(value[THR_W-1:0]);
  endtask

  // With no taps set every trace end gives an all-zero result.
  task automatic test_tables_unset();
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    send_sample(SAMPLE_FULL, 1'b1);
    send_item(make_other(OP_IGNORED, 6'd63, 16'sh7fff));
    send_sample(10'd0, 1'b0);
    send_sample(SAMPLE_FULL, 1'b0);
    send_sample(10'd512, 1'b1);
    wait_drained();
  endtask

  // Every weight is written before any tap is used.
  task automatic test_fill_tables();
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    for (int i = 0; i < MAX_TAPS; i++) begin
      load_weight(OP_LOAD_AMP, IDX_W'(i), WFIELD_W'($urandom_range(0, 65535)));
      load_weight(OP_LOAD_TIME, IDX_W'(i), WFIELD_W'($urandom_range(0, 65535)));
    end
    wait_drained();
  endtask

  // Full-scale forcing at the reset threshold, zero amplitude and weight extremes.
  task automatic test_amplitude_cases();
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    write_reg(REG_TAP_COUNT, 16'd1);
    load_weight(OP_LOAD_AMP, 6'd0, 16'sd8192);
    load_weight(OP_LOAD_TIME, 6'd0, 16'sd4096);
    send_sample(SAMPLE_FULL, 1'b1);
    send_sample(10'd1022, 1'b1);
    send_sample(10'd0, 1'b1);
    load_weight(OP_LOAD_AMP, 6'd0, -16'sd32768);
    send_sample(SAMPLE_FULL, 1'b1);
    load_weight(OP_LOAD_AMP, 6'd0, 16'sd32767);
    load_weight(OP_LOAD_TIME, 6'd0, -16'sd32768);
    send_sample(SAMPLE_FULL, 1'b1);
    wait_drained();
  endtask

  // A tiny amplitude against a large time sum drives the quotient into saturation.
  task automatic test_time_saturation();
    write_reg(REG_TAP_COUNT, 16'd2);
    load_weight(OP_LOAD_AMP, 6'd0, 16'sd1);
    load_weight(OP_LOAD_AMP, 6'd1, -16'sd1);
    load_weight(OP_LOAD_TIME, 6'd0, 16'sd32767);
    load_weight(OP_LOAD_TIME, 6'd1, 16'sd32767);
    send_sample(SAMPLE_FULL, 1'b0);
    send_sample(10'd1022, 1'b1);
    load_weight(OP_LOAD_TIME, 6'd0, -16'sd32768);
    load_weight(OP_LOAD_TIME, 6'd1, -16'sd32768);
    send_sample(SAMPLE_FULL, 1'b0);
    send_sample(10'd1022, 1'b1);
    wait_drained();
  endtask

  // Loads and ignored operations inside a trace, and samples beyond the taps.
  task automatic test_trace_interleave();
    send_sample(10'd700, 1'b0);
    load_weight(OP_LOAD_AMP, 6'd1, 16'sd2048);
    send_item(make_other(OP_IGNORED, 6'd0, -16'sd1));
    send_sample(10'd300, 1'b0);
    send_sample(SAMPLE_FULL, 1'b0);
    send_sample(10'd5, 1'b1);
    wait_drained();
  endtask

  // New register settings for one random phase, extremes included.
  task automatic pick_config();
    int r;
    int unsigned taps;
    int unsigned thr;
    r = $urandom_range(0, 11);
    case (r)
      0:       taps = 0;
      1:       taps = MAX_TAPS;
      2:       taps = 127;
      3:       taps = $urandom_range(MAX_TAPS + 1, 126);
      4:       taps = 1;
      5:       taps = $urandom_range(17, MAX_TAPS - 1);
      default: taps = $urandom_range(2, 16);
    endcase
    write_reg(REG_TAP_COUNT, CFG_DATA_W'(taps));
    if ($urandom_range(0, 2) == 0) begin
      r = $urandom_range(0, 5);
      case (r)
        0:       thr = 0;
        1:       thr = 65535;
        2:       thr = THR_RESET;
        3:       thr = $urandom_range(0, 65535);
        default: thr = $urandom_range(0, 4000);
      endcase
      write_reg(REG_AMP_THRESHOLD, CFG_DATA_W'(thr));
    end
  endtask

  // One trace with random content, occasional loads and ignored items mixed in.
  task automatic run_trace();
    int unsigned taps;
    int len;
    int r;
    bit quiet;
    taps = (tap_limit > MAX_TAPS) ? MAX_TAPS : tap_limit;
    r = $urandom_range(0, 19);
    if (taps == 0) len = $urandom_range(1, 4);
    else if (r < 12) len = taps;
    else if (r < 17) len = $urandom_range(1, taps);
    else len = taps + $urandom_range(1, 4);
    quiet = ($urandom_range(0, 7) == 0);
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(0, 9) == 0)
        load_weight($urandom_range(0, 1) ? OP_LOAD_TIME : OP_LOAD_AMP,
                    IDX_W'($urandom_range(0, 63)), WFIELD_W'($urandom_range(0, 65535)));
      if ($urandom_range(0, 29) == 0)
        send_item(make_other(OP_IGNORED, IDX_W'($urandom_range(0, 63)),
                             WFIELD_W'($urandom_range(0, 65535))));
      send_sample(quiet ? 10'd0 : pick_sample(), k == len - 1);
    end
  endtask

  task automatic test_random_traces();
    int start;
    int traces;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      wait_drained();
      pick_config();
      gaps_on = ($urandom_range(0, 3) != 0);
      stalls_on = ($urandom_range(0, 3) != 0);
      traces = $urandom_range(1, 4);
      repeat (traces) run_trace();
    end
    wait_drained();
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_bus.valid = 1'b0;
    in_bus.operation = OP_SAMPLE;
    in_bus.weight_index = '0;
    in_bus.weight_value = '0;
    in_bus.sample = '0;
    in_bus.last_sample = 1'b0;
    out_bus.ready = 1'b0;
    tap_limit = 0;
    amp_limit = THR_RESET;
    amp_acc = 0;
    time_acc = 0;
    peak_seen = 0;
    taps_taken = 0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    test_tables_unset();
    test_fill_tables();
    test_amplitude_cases();
    test_time_saturation();
    test_trace_interleave();
    test_random_traces();

    if (err_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Hard stop well past the slowest correct run.
  initial begin
    #50000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

@@ files.f @@
rtl/ppws_pkg.sv
rtl/ppws_in_if.sv
rtl/ppws_out_if.sv
rtl/ppws_ram.sv
rtl/ppws_mac.sv
rtl/ppws_div.sv
rtl/pulse_peak_weighted_sum_top.sv
bench/tb_top.sv
